// ===== rtl/vpbn_pkg.sv =====
// ============================================================================
// vpbn_pkg
// Shared types and constants for the vertex projection and bounding-box
// normalize unit.
// ============================================================================
package vpbn_pkg;

    localparam int MaxVertices = 64;
    localparam int FracBits    = 16;
    localparam int DataW       = 32;
    localparam int OutW        = 17;
    localparam int AddrW       = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
    localparam int CountW      = $clog2(MaxVertices + 1);
    localparam int QuoW        = FracBits + 33;
    localparam int QuoHiW      = QuoW - 32;
    localparam int DivCntW     = $clog2(QuoW);
    localparam int SumW        = QuoHiW + 33;
    localparam int CfgIdxW     = 2;

    localparam logic [CfgIdxW-1:0] CfgScaleX  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgScaleY  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgOffsetX = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgOffsetY = 2'd3;

    localparam logic signed [DataW-1:0] ScaleReset  = 32'sh0001_0000;
    localparam logic signed [DataW-1:0] OffsetReset = 32'sh0000_0000;
    localparam logic signed [DataW-1:0] Half        = DataW'(1) <<< (FracBits - 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_DRAIN,
        S_DIVIDE,
        S_EMIT,
        S_FLUSH,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic load_en;
        logic div_start;
        logic emit_issue;
        logic clear;
    } t_ctrl_cmd;

    typedef struct packed {
        logic load_busy;
        logic store_empty;
        logic div_busy;
        logic emit_adv;
        logic emit_last;
        logic emit_busy;
    } t_ctrl_sts;

endpackage

// ===== rtl/vpbn_ram.sv =====
// ============================================================================
// vpbn_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module vpbn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vpbn_ctrl.sv =====
// ============================================================================
// vpbn_ctrl
// Run controller: load, drain, reciprocal, emit, flush and clear sequencing.
// ============================================================================
module vpbn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_final_vertex,
    output logic                o_in_stall,
    output vpbn_pkg::t_ctrl_cmd o_cmd,
    input  vpbn_pkg::t_ctrl_sts i_sts
);
    import vpbn_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.load_en    = 1'b0;
        o_cmd.div_start  = 1'b0;
        o_cmd.emit_issue = 1'b0;
        o_cmd.clear      = 1'b0;
        o_in_stall       = (r_state != S_LOAD);
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load_en = i_in_valid;
                if (i_in_valid && i_final_vertex) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.load_busy) begin
                    if (i_sts.store_empty) begin
                        n_state = S_CLEAR;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIVIDE;
                    end
                end
            end
            S_DIVIDE: begin
                if (!i_sts.div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_issue = 1'b1;
                if (i_sts.emit_adv && i_sts.emit_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_sts.emit_busy) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/vpbn_dp.sv =====
// ============================================================================
// vpbn_dp
// Datapath: projection pipeline, vertex store, bounding box, bit-serial
// reciprocal and the normalize pipeline toward the output register.
// ============================================================================
module vpbn_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  vpbn_pkg::t_ctrl_cmd                    i_cmd,
    output vpbn_pkg::t_ctrl_sts                    o_sts,
    input  logic                                   i_cfg_we,
    input  logic [vpbn_pkg::CfgIdxW-1:0]           i_cfg_idx,
    input  logic [vpbn_pkg::DataW-1:0]             i_cfg_data,
    input  logic signed [vpbn_pkg::DataW-1:0]      i_vertex_x,
    input  logic signed [vpbn_pkg::DataW-1:0]      i_vertex_y,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic [vpbn_pkg::OutW-1:0]              o_norm_x,
    output logic [vpbn_pkg::OutW-1:0]              o_norm_y,
    output logic                                   o_zero_extent,
    output logic                                   o_dropped,
    output logic                                   o_end_of_run
);
    import vpbn_pkg::*;

    localparam logic [SumW-1:0] OutOne = SumW'(1) << FracBits;

    // configuration
    logic signed [DataW-1:0] r_scale_x, r_scale_y, r_offset_x, r_offset_y;

    // projection pipeline
    logic                      r_v1, r_v2;
    logic signed [2*DataW-1:0] r_prod_x, r_prod_y;
    logic signed [DataW-1:0]   r_wx, r_wy;
    logic signed [DataW-1:0]   n_wx, n_wy;

    // bounding box and store bookkeeping
    logic [CountW-1:0]       r_count;
    logic signed [DataW-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic                    r_overflow;
    logic                    store_full;
    logic                    ram_we;

    // reciprocal
    logic               r_div_busy;
    logic [DivCntW-1:0] r_div_cnt;
    logic [DataW-1:0]   r_ext_x, r_ext_y;
    logic [DataW-1:0]   r_rem_x, r_rem_y;
    logic [QuoW-1:0]    r_quo_x, r_quo_y;
    logic               r_zero;
    logic               div_bit;
    logic [DataW:0]     n_rem_sh_x, n_rem_sh_y;
    logic               ge_x, ge_y;

    // normalize pipeline
    logic                     adv;
    logic                     issue;
    logic                     issue_last;
    logic [AddrW-1:0]         r_rd_idx;
    logic [2*DataW-1:0]       ram_rdata;
    logic                     r_e_v1, r_e_v2, r_e_v3, r_o_valid;
    logic                     r_e_l1, r_e_l2, r_e_l3, r_o_last;
    logic [DataW-1:0]         r_dx, r_dy;
    logic [DataW-1:0]         n_dx, n_dy;
    logic [2*DataW-1:0]       r_plo_x, r_plo_y;
    logic [DataW+QuoHiW-1:0]  r_phi_x, r_phi_y;
    logic [SumW-1:0]          n_sum_x, n_sum_y;
    logic [OutW-1:0]          r_nx, r_ny;

    function automatic logic signed [DataW-1:0] to_window(
        input logic signed [2*DataW-1:0] prod,
        input logic signed [DataW-1:0]   ofs
    );
        logic signed [2*DataW-1:0] sh;
        logic signed [DataW+16:0]  sum;
        logic signed [DataW-1:0]   p;
        sh  = prod >>> FracBits;
        sum = (DataW+17)'(sh) + (DataW+17)'(ofs);
        if (sum > (DataW+17)'(signed'(32'sh7FFF_FFFF))) begin
            p = 32'sh7FFF_FFFF;
        end else if (sum < (DataW+17)'(signed'(32'sh8000_0000))) begin
            p = 32'sh8000_0000;
        end else begin
            p = sum[DataW-1:0];
        end
        return (p >>> 1) + Half;
    endfunction

    function automatic logic [DataW-1:0] clamp_diff(
        input logic signed [DataW-1:0] w,
        input logic signed [DataW-1:0] lo,
        input logic [DataW-1:0]        ext
    );
        logic signed [DataW:0] d;
        d = (DataW+1)'(w) - (DataW+1)'(lo);
        if (d[DataW]) begin
            return '0;
        end else if (d[DataW-1:0] > ext) begin
            return ext;
        end
        return d[DataW-1:0];
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x  <= ScaleReset;
            r_scale_y  <= ScaleReset;
            r_offset_x <= OffsetReset;
            r_offset_y <= OffsetReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgScaleX:  r_scale_x  <= i_cfg_data;
                CfgScaleY:  r_scale_y  <= i_cfg_data;
                CfgOffsetX: r_offset_x <= i_cfg_data;
                CfgOffsetY: r_offset_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // projection: multiply, then window map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.load_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_prod_x <= i_vertex_x * r_scale_x;
            r_prod_y <= i_vertex_y * r_scale_y;
        end
        if (r_v1) begin
            r_wx <= n_wx;
            r_wy <= n_wy;
        end
    end

    assign n_wx = to_window(r_prod_x, r_offset_x);
    assign n_wy = to_window(r_prod_y, r_offset_y);

    // commit to the store and the bounding box
    assign store_full = (r_count == CountW'(MaxVertices));
    assign ram_we     = r_v2 && !store_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count    <= '0;
            r_min_x    <= Half;
            r_max_x    <= Half;
            r_min_y    <= Half;
            r_max_y    <= Half;
            r_overflow <= 1'b0;
        end else if (r_v2) begin
            if (store_full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count <= r_count + CountW'(1);
                if (r_wx < r_min_x) r_min_x <= r_wx;
                if (r_wx > r_max_x) r_max_x <= r_wx;
                if (r_wy < r_min_y) r_min_y <= r_wy;
                if (r_wy > r_max_y) r_max_y <= r_wy;
            end
        end
    end

    vpbn_ram #(
        .WIDTH(2 * DataW),
        .DEPTH(MaxVertices)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AddrW-1:0]),
        .i_wdata({r_wy, r_wx}),
        .i_re   (adv),
        .i_raddr(r_rd_idx),
        .o_rdata(ram_rdata)
    );

    // restoring reciprocal, one quotient bit per cycle on each axis
    assign div_bit    = (r_div_cnt == DivCntW'(QuoW - 1));
    assign n_rem_sh_x = {r_rem_x, div_bit};
    assign n_rem_sh_y = {r_rem_y, div_bit};
    assign ge_x       = (n_rem_sh_x >= {1'b0, r_ext_x});
    assign ge_y       = (n_rem_sh_y >= {1'b0, r_ext_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
        end else if (r_div_busy && r_div_cnt == '0) begin
            r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_ext_x   <= DataW'(r_max_x - r_min_x);
            r_ext_y   <= DataW'(r_max_y - r_min_y);
            r_zero    <= (r_max_x == r_min_x) || (r_max_y == r_min_y);
            r_rem_x   <= '0;
            r_rem_y   <= '0;
            r_quo_x   <= '0;
            r_quo_y   <= '0;
            r_div_cnt <= DivCntW'(QuoW - 1);
        end else if (r_div_busy) begin
            r_rem_x   <= ge_x ? DataW'(n_rem_sh_x - {1'b0, r_ext_x}) : n_rem_sh_x[DataW-1:0];
            r_rem_y   <= ge_y ? DataW'(n_rem_sh_y - {1'b0, r_ext_y}) : n_rem_sh_y[DataW-1:0];
            r_quo_x   <= {r_quo_x[QuoW-2:0], ge_x};
            r_quo_y   <= {r_quo_y[QuoW-2:0], ge_y};
            r_div_cnt <= r_div_cnt - DivCntW'(1);
        end
    end

    // normalize pipeline: read, clamp, partial products, sum and saturate
    assign adv        = !r_o_valid || !i_out_stall;
    assign issue      = i_cmd.emit_issue && adv;
    assign issue_last = (CountW'(r_rd_idx) == r_count - CountW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_e_v1    <= 1'b0;
            r_e_v2    <= 1'b0;
            r_e_v3    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_rd_idx <= '0;
            end else if (issue) begin
                r_rd_idx <= r_rd_idx + AddrW'(1);
            end
            if (adv) begin
                r_e_v1    <= issue;
                r_e_v2    <= r_e_v1;
                r_e_v3    <= r_e_v2;
                r_o_valid <= r_e_v3;
            end
        end
    end

    assign n_dx    = clamp_diff(ram_rdata[DataW-1:0], r_min_x, r_ext_x);
    assign n_dy    = clamp_diff(ram_rdata[2*DataW-1:DataW], r_min_y, r_ext_y);
    assign n_sum_x = SumW'(r_phi_x) + SumW'(r_plo_x[2*DataW-1:DataW]);
    assign n_sum_y = SumW'(r_phi_y) + SumW'(r_plo_y[2*DataW-1:DataW]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_l1   <= issue_last;
            r_e_l2   <= r_e_l1;
            r_e_l3   <= r_e_l2;
            r_o_last <= r_e_l3;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_plo_x  <= r_dx * r_quo_x[DataW-1:0];
            r_plo_y  <= r_dy * r_quo_y[DataW-1:0];
            r_phi_x  <= r_dx * r_quo_x[QuoW-1:DataW];
            r_phi_y  <= r_dy * r_quo_y[QuoW-1:DataW];
            r_nx     <= (n_sum_x > OutOne) ? OutOne[OutW-1:0] : n_sum_x[OutW-1:0];
            r_ny     <= (n_sum_y > OutOne) ? OutOne[OutW-1:0] : n_sum_y[OutW-1:0];
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_norm_x      = r_nx;
    assign o_norm_y      = r_ny;
    assign o_zero_extent = r_zero;
    assign o_dropped     = r_overflow;
    assign o_end_of_run  = r_o_last;

    assign o_sts.load_busy   = r_v1 || r_v2;
    assign o_sts.store_empty = (r_count == '0);
    assign o_sts.div_busy    = r_div_busy;
    assign o_sts.emit_adv    = adv;
    assign o_sts.emit_last   = issue_last;
    assign o_sts.emit_busy   = r_e_v1 || r_e_v2 || r_e_v3 || r_o_valid;

endmodule

// ===== rtl/vertex_project_bbox_normalize_unit.sv =====
// ============================================================================
// vertex_project_bbox_normalize_unit
// Projects 2D mask vertices to window space, tracks their bounding box and,
// on the final vertex, emits every stored vertex fitted into the unit square.
// ============================================================================
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    vertex_x, vertex_y, final_vertex
//   output    out        o_out_valid / i_out_stall  norm_x, norm_y, zero_extent,
//                                                   dropped, end_of_run
//   config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Vertices transfer one per cycle while a run loads. After the final vertex the
// input stalls while the unit drains the projection pipeline, runs the
// bit-serial reciprocal and its hand-off, reads every stored vertex, flushes
// the normalize pipeline and clears the run state. Output stalls freeze the
// normalize pipeline and the store read port and add to the input stall. Reset
// is synchronous and needs no clearing pass; the store is read only at entries
// written in the current run.
// ============================================================================
module vertex_project_bbox_normalize_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vpbn_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [vpbn_pkg::DataW-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [vpbn_pkg::DataW-1:0]  i_vertex_x,
    input  logic signed [vpbn_pkg::DataW-1:0]  i_vertex_y,
    input  logic                               i_final_vertex,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [vpbn_pkg::OutW-1:0]          o_norm_x,
    output logic [vpbn_pkg::OutW-1:0]          o_norm_y,
    output logic                               o_zero_extent,
    output logic                               o_dropped,
    output logic                               o_end_of_run
);
    import vpbn_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    vpbn_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_final_vertex(i_final_vertex),
        .o_in_stall    (o_in_stall),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    vpbn_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_vertex_x   (i_vertex_x),
        .i_vertex_y   (i_vertex_y),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_norm_x     (o_norm_x),
        .o_norm_y     (o_norm_y),
        .o_zero_extent(o_zero_extent),
        .o_dropped    (o_dropped),
        .o_end_of_run (o_end_of_run)
    );

endmodule
